// ----- hdl/vsd_pkg.sv -----
// Shared types and constants for the varint stream decoder.
`default_nettype none

package vsd_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned CountWidth = 4;
    localparam int unsigned StatWidth  = 2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_TRUNC  = 2'd1;
    localparam logic [1:0] STAT_UNTERM = 2'd2;

    localparam logic FMT_COMPACT = 1'b0;
    localparam logic FMT_BASE128 = 1'b1;

    localparam logic [7:0] PREFIX_U16 = 8'd253;
    localparam logic [7:0] PREFIX_U32 = 8'd254;
    localparam logic [7:0] GROUP_MASK = 8'h7F;
    localparam logic [7:0] CONT_BIT   = 8'h80;

    localparam logic [3:0] LEN_U16 = 4'd3;
    localparam logic [3:0] LEN_U32 = 4'd5;
    localparam logic [3:0] LEN_U64 = 4'd9;

    typedef struct packed {
        logic [ValueWidth-1:0] acc;
        logic [CountWidth-1:0] byte_count;
        logic [CountWidth-1:0] expected_length;
    } t_dec_state;

    typedef struct packed {
        logic [StatWidth-1:0]  status;
        logic [CountWidth-1:0] bytes_used;
        logic [ValueWidth-1:0] value;
    } t_dec_result;

endpackage

`default_nettype wire

// ----- hdl/vsd_step.sv -----
// Next-state and result logic for one byte of the varint decoder.
`default_nettype none

module vsd_step
    import vsd_pkg::*;
#(
    parameter int unsigned MAX_GROUPS = 10
) (
    input  wire logic        i_format,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire t_dec_state  i_state,
    output t_dec_state       o_state,
    output logic             o_res_valid,
    output t_dec_result      o_result
);

    localparam logic [CountWidth-1:0] MaxGroups = CountWidth'(MAX_GROUPS);

    logic [CountWidth-1:0] bc_m1;
    logic [CountWidth-1:0] bc_p1;
    logic [5:0]            sh_c;
    logic [6:0]            sh_b;
    logic [ValueWidth-1:0] acc_c;
    logic [ValueWidth-1:0] acc_b;

    always_comb begin
        bc_m1 = i_state.byte_count - 4'd1;
        bc_p1 = i_state.byte_count + 4'd1;
        sh_c  = {bc_m1[2:0], 3'b000};
        sh_b  = {i_state.byte_count, 3'b000} - 7'(i_state.byte_count);
        acc_c = i_state.acc | (ValueWidth'(i_byte) << sh_c);
        acc_b = i_state.acc;
        if (!sh_b[6]) begin
            acc_b = i_state.acc | (ValueWidth'(i_byte & GROUP_MASK) << sh_b[5:0]);
        end
    end

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_result    = '0;
        if (i_format == FMT_COMPACT) begin
            if (i_state.byte_count == '0) begin
                if (i_byte < PREFIX_U16) begin
                    o_res_valid         = 1'b1;
                    o_result.value      = ValueWidth'(i_byte);
                    o_result.bytes_used = 4'd1;
                    o_result.status     = STAT_OK;
                    o_state             = '0;
                end else begin
                    o_state.acc        = '0;
                    o_state.byte_count = 4'd1;
                    if (i_byte == PREFIX_U16) begin
                        o_state.expected_length = LEN_U16;
                    end else if (i_byte == PREFIX_U32) begin
                        o_state.expected_length = LEN_U32;
                    end else begin
                        o_state.expected_length = LEN_U64;
                    end
                    if (i_last) begin
                        o_res_valid     = 1'b1;
                        o_result.status = STAT_TRUNC;
                        o_state         = '0;
                    end
                end
            end else begin
                o_state.acc        = acc_c;
                o_state.byte_count = bc_p1;
                if (bc_p1 >= i_state.expected_length) begin
                    o_res_valid         = 1'b1;
                    o_result.value      = acc_c;
                    o_result.bytes_used = bc_p1;
                    o_result.status     = STAT_OK;
                    o_state             = '0;
                end else if (i_last) begin
                    o_res_valid     = 1'b1;
                    o_result.status = STAT_TRUNC;
                    o_state         = '0;
                end
            end
        end else begin
            o_state.acc        = acc_b;
            o_state.byte_count = bc_p1;
            if ((i_byte & CONT_BIT) == 8'h00) begin
                o_res_valid         = 1'b1;
                o_result.value      = acc_b;
                o_result.bytes_used = bc_p1;
                o_result.status     = STAT_OK;
                o_state             = '0;
            end else if (bc_p1 >= MaxGroups || i_last) begin
                o_res_valid         = 1'b1;
                o_result.value      = acc_b;
                o_result.bytes_used = bc_p1;
                o_result.status     = STAT_UNTERM;
                o_state             = '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/varint_stream_decoder_top.sv -----
// Top level of the varint stream decoder: input register, step logic, result register.
//
//   channel   dir  payload
//   s_axis    in   tdata = data_byte, tlast = end_of_buffer
//   m_axis    out  tdata = decoded_value, bytes_used, status
//   format    in   write enable + 1-bit format_select
//
// One byte per cycle while the output is not stalled: a byte is held in the
// input register, the step logic updates the decoder state, and a result
// lands in the output register when a value ends. An input byte passes the
// input register and then the result register before its result is valid.
// Reset clears the valid flags, the state and format_select (compact form).
// A stalled output holds the result; the input register still takes a byte
// while it is empty, so the stream keeps one byte per cycle when not stalled.
`default_nettype none

module varint_stream_decoder_top
    import vsd_pkg::*;
#(
    parameter int unsigned MAX_GROUPS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_format_wr_en,
    input  wire logic        i_format_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // [63:0] decoded_value, [67:64] bytes_used,
                                             // [69:68] status, [71:70] zero
);

    logic        r_format;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_dec_state  r_state;
    t_dec_state  n_state;
    logic        r_out_valid;
    t_dec_result r_out;
    t_dec_result n_out;
    logic        res_valid;
    logic        advance;
    logic        in_xfer;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    vsd_step #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_step (
        .i_format    (r_format),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FMT_COMPACT;
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_format_wr_en) begin
                r_format <= i_format_wr_data;
                r_state  <= '0;
            end else if (advance) begin
                r_state <= n_state;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && res_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.status, r_out.bytes_used, r_out.value};

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for varint_stream_decoder_top: queued byte stream driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb;
    import vsd_pkg::*;

    localparam int unsigned MaxGroups = 10;
    localparam logic [7:0] PrefixU64 = 8'hFF;
    localparam int DrainCycles = 6;
    localparam int PhaseItems = 90;
    localparam int RandomPhases = 8;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } t_stream_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_format_wr_en = 1'b0;
    logic        i_format_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // [63:0] decoded_value, [67:64] bytes_used,
                                      // [69:68] status, [71:70] zero

    t_stream_byte byte_q[$];
    t_dec_result  decoded_q[$];
    int           err_count = 0;
    int           n_pushed = 0;

    logic        fmt_sel = FMT_COMPACT;
    logic [63:0] dec_acc = '0;
    logic [3:0]  dec_cnt = '0;
    logic [3:0]  dec_len = '0;

    int          burst_left = 8;
    int          gap_left = 0;
    logic [15:0] rdy_pat = 16'hFFFF;
    int          rdy_left = 40;

    varint_stream_decoder_top #(
        .MAX_GROUPS(MaxGroups)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_format_wr_en(i_format_wr_en),
        .i_format_wr_data(i_format_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit close_value(output t_dec_result r, input logic [63:0] v,
                                       input logic [3:0] n, input logic [1:0] st);
        r.value = v;
        r.bytes_used = n;
        r.status = st;
        dec_acc = '0;
        dec_cnt = '0;
        dec_len = '0;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic eob,
                                       output t_dec_result r);
        logic [5:0] sh;
        int unsigned gsh;
        r = '0;
        if (fmt_sel == FMT_COMPACT) begin
            if (dec_cnt == 0) begin
                if (b < PREFIX_U16) return close_value(r, 64'(b), 4'd1, STAT_OK);
                dec_len = (b == PREFIX_U16) ? LEN_U16 : (b == PREFIX_U32) ? LEN_U32 : LEN_U64;
                dec_acc = '0;
                dec_cnt = 4'd1;
                if (eob) return close_value(r, '0, '0, STAT_TRUNC);
                return 1'b0;
            end
            sh = 6'(8 * (dec_cnt - 1));
            dec_acc = dec_acc | (64'(b) << sh);
            dec_cnt = dec_cnt + 4'd1;
            if (dec_cnt >= dec_len) return close_value(r, dec_acc, dec_cnt, STAT_OK);
            if (eob) return close_value(r, '0, '0, STAT_TRUNC);
            return 1'b0;
        end
        gsh = 7 * dec_cnt;
        if (gsh <= 63) dec_acc = dec_acc | (64'(b & GROUP_MASK) << gsh);
        dec_cnt = dec_cnt + 4'd1;
        if ((b & CONT_BIT) == 0) return close_value(r, dec_acc, dec_cnt, STAT_OK);
        if (dec_cnt >= MaxGroups || eob) return close_value(r, dec_acc, dec_cnt, STAT_UNTERM);
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eob);
        t_stream_byte it;
        it.data = b;
        it.eob = eob;
        byte_q.push_back(it);
        n_pushed++;
    endtask

    // shape: 0 whole value, 1 buffer ends inside the value
    task automatic add_compact(input int shape);
        int kind;
        int n;
        int stop;
        logic [7:0] pfx;
        kind = $urandom_range(0, 3);
        if (kind == 0) begin
            push_byte(8'($urandom_range(0, PREFIX_U16 - 1)), $urandom_range(0, 9) == 0);
        end else begin
            pfx = (kind == 1) ? PREFIX_U16 : (kind == 2) ? PREFIX_U32 : PrefixU64;
            n = (kind == 1) ? 2 : (kind == 2) ? 4 : 8;
            stop = (shape == 1) ? $urandom_range(0, n - 1) : n;
            push_byte(pfx, shape == 1 && stop == 0);
            for (int k = 1; k <= stop; k++)
                push_byte(8'($urandom),
                          k == stop && (shape == 1 || $urandom_range(0, 9) == 0));
        end
    endtask

    // shape: 0 whole value, 1 buffer ends early, 2 all groups continue
    task automatic add_base128(input int shape);
        int len;
        logic [7:0] b;
        if (shape == 2)
            len = MaxGroups;
        else if (shape == 1)
            len = $urandom_range(1, MaxGroups - 1);
        else
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxGroups)
                                              : $urandom_range(1, 3);
        for (int k = 1; k <= len; k++) begin
            b = 8'($urandom);
            if (k < len || shape != 0)
                b = b | CONT_BIT;
            else
                b = b & GROUP_MASK;
            push_byte(b, k == len && (shape == 1 || $urandom_range(0, 9) == 0));
        end
    endtask

    task automatic fill_random(input int count);
        int start;
        int pick;
        start = n_pushed;
        while (n_pushed - start < count) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                push_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end else if (fmt_sel == FMT_COMPACT) begin
                add_compact(pick < 5 ? 1 : 0);
            end else begin
                add_base128(pick < 4 ? 1 : pick < 6 ? 2 : 0);
            end
        end
        // leave a value open so the next format write abandons it
        if ($urandom_range(0, 1) == 0) begin
            if (fmt_sel == FMT_COMPACT) begin
                push_byte(PrefixU64, 1'b0);
                push_byte(8'($urandom), 1'b0);
            end else begin
                push_byte(8'($urandom) | CONT_BIT, 1'b0);
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_format(input logic v);
        @(posedge i_clk);
        i_format_wr_en <= 1'b1;
        i_format_wr_data <= v;
        @(posedge i_clk);
        i_format_wr_en <= 1'b0;
        fmt_sel = v;
        dec_acc = '0;
        dec_cnt = '0;
        dec_len = '0;
    endtask

    always @(posedge i_clk) begin : drv_proc
        t_stream_byte it;
        t_dec_result  r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_byte(s_axis_tdata, s_axis_tlast, r)) decoded_q.push_back(r);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    it = byte_q.pop_front();
                    s_axis_tdata <= it.data;
                    s_axis_tlast <= it.eob;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : rdy_proc
        if (rdy_left == 0) begin
            rdy_left = $urandom_range(20, 80);
            rdy_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end else begin
            rdy_left--;
            rdy_pat = {rdy_pat[14:0], rdy_pat[15]};
        end
        m_axis_tready <= rdy_pat[0];
    end

    always @(posedge i_clk) begin : mon_proc
        t_dec_result got;
        t_dec_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[69:0];
            if (decoded_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected transfer: value=%h used=%0d status=%0d",
                             got.value, got.bytes_used, got.status);
            end else begin
                want = decoded_q.pop_front();
                if (got !== want || m_axis_tdata[71:70] !== 2'b00) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("transfer differs: expected value=%h used=%0d status=%0d",
                                 want.value, want.bytes_used, want.status);
                        $display("  got value=%h used=%0d status=%0d pad=%b",
                                 got.value, got.bytes_used, got.status, m_axis_tdata[71:70]);
                    end
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_format(FMT_COMPACT);

        push_byte(8'd252, 1'b1);
        push_byte(PREFIX_U16, 1'b1);
        push_byte(PREFIX_U32, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(PrefixU64, 1'b0);
        for (int k = 0; k < 8; k++) push_byte(8'hFF, 1'b0);
        push_byte(PrefixU64, 1'b0);
        push_byte(8'h11, 1'b0);
        wait_drained();
        write_format(FMT_BASE128);

        push_byte(GROUP_MASK, 1'b0);
        for (int k = 0; k < MaxGroups; k++) push_byte(8'hFF, 1'b0);
        push_byte(CONT_BIT, 1'b1);

        for (int ph = 0; ph < RandomPhases; ph++) begin
            wait_drained();
            write_format((ph % 2 == 0) ? FMT_COMPACT : FMT_BASE128);
            fill_random(PhaseItems);
        end
        wait_drained();

        if (err_count == 0) begin
            $display("varint_stream_decoder_top: match");
        end else begin
            $display("varint_stream_decoder_top: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("varint_stream_decoder_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/vsd_pkg.sv
hdl/vsd_step.sv
hdl/varint_stream_decoder_top.sv
dv/tb.sv
